@@ hdl/first_fit_table_space_allocator_macros.svh @@
// Assertion macros used by the allocator's top-level RTL file.
`ifndef FIRST_FIT_TABLE_SPACE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_TABLE_SPACE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FFTSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FFTSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/fftsa_pkg.sv @@
// Types and codes shared by the first-fit table space allocator.
package fftsa_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;
  localparam int SIZE_BITS      = 24;
  localparam int LEN_BITS       = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_REGION_BASE      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REGION_BYTES     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL1_BYTES     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL2_BYTES     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DESCRIPTOR_BYTES = 3'd4;

  // Request opcodes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Table kinds; the unused code is handled as a segment table.
  localparam logic [1:0] KIND_LEVEL1  = 2'd0;
  localparam logic [1:0] KIND_LEVEL2  = 2'd1;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NO_FIT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [1:0]  table_kind;
    logic [15:0] segment_pages;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    logic [31:0] alloc_address;
    logic [1:0]  status;
  } resp_t;

endpackage

@@ hdl/first_fit_table_space_allocator.sv @@
// Top level of the first-fit table space allocator.
// Usage. Requests arrive as beats on in_valid, in_stall and in_data; each one
// gives exactly one result beat on out_valid, out_stall and out_data. A beat
// moves at a rising edge where valid is high and stall is low. An allocate
// returns the base of the first free segment large enough for the table kind;
// a free inserts the block into the address-ordered list without merging it.
// Structure. One RAM with a registered read holds the list, and a single
// compare unit walks it one entry per cycle. An allocate walks up from entry
// zero to the first entry that fits; when that segment is used up, the entries
// above it move down by one. A free walks down from the top, moving each entry
// above the block up by one, and a free into a full table goes straight to
// the result without a walk.
// One request is in flight at a time; in_stall is low only when idle. The
// next request may be accepted while the previous result still waits.
// Reset. A synchronous reset loads the default registers and then, in the
// S_INIT state, writes the single segment that spans the region into the RAM;
// a write to region_base or region_bytes reloads the table the same way.
// Stall. While out_stall is high the result beat holds, and a finished
// request waits in its last state until the output register frees.
module first_fit_table_space_allocator #(
  parameter int MAX_SEGMENTS = 64,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [fftsa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [fftsa_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  fftsa_pkg::req_t                      in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output fftsa_pkg::resp_t                     out_data
);

  import fftsa_pkg::*;

  `include "first_fit_table_space_allocator_macros.svh"

  localparam int AW = ADDRESS_BITS;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = AW + LEN_BITS;

  typedef enum logic [5:0] {
    S_INIT    = 6'b000001,
    S_IDLE    = 6'b000010,
    S_A_SCAN  = 6'b000100,
    S_A_SHIFT = 6'b001000,
    S_F_SCAN  = 6'b010000,
    S_FINISH  = 6'b100000
  } state_t;

  // Configuration registers.
  logic [31:0] region_base;
  logic [31:0] region_bytes;
  logic [15:0] level1_bytes;
  logic [15:0] level2_bytes;
  logic [7:0]  descriptor_bytes;
  logic [31:0] region_base_next;
  logic [31:0] region_bytes_next;
  logic        region_write;

  // Sequencer state.
  state_t         state;
  logic [CW-1:0]  count;
  logic [CW-1:0]  ptr;
  logic [CW-1:0]  ptr_dec;
  logic [IW-1:0]  chk_idx;
  logic           chk_valid;
  logic [SIZE_BITS-1:0] size;
  logic [SIZE_BITS-1:0] size_req;
  logic [AW-1:0]  free_addr;
  logic [31:0]    res_addr;
  logic [1:0]     res_status;

  // RAM ports.
  logic           ram_we;
  logic [IW-1:0]  ram_waddr;
  logic [EW-1:0]  ram_wdata;
  logic [IW-1:0]  ram_raddr;
  logic [EW-1:0]  ram_rdata;
  logic           fsm_we;
  logic [IW-1:0]  fsm_waddr;
  logic [EW-1:0]  fsm_wdata;

  // Entry under test and the decisions taken on it.
  logic [AW-1:0]       rd_base;
  logic [LEN_BITS-1:0] rd_len;
  logic [LEN_BITS-1:0] rest;
  logic                fit;
  logic                shift_up;
  logic [EW-1:0]       new_entry;
  logic [EW-1:0]       load_entry;

  // Conditions watched by the assertions.
  logic finishing;
  logic has_room;
  logic res_full;
  logic full_free_beat;

  // ---------------------------------------------------------------------
  // Configuration port. Region writes reload the table in the same cycle.
  // ---------------------------------------------------------------------
  assign region_write = cfg_write &&
                        (cfg_index == REG_REGION_BASE || cfg_index == REG_REGION_BYTES);
  assign region_base_next  = (cfg_write && cfg_index == REG_REGION_BASE) ?
                             cfg_data : region_base;
  assign region_bytes_next = (cfg_write && cfg_index == REG_REGION_BYTES) ?
                             cfg_data : region_bytes;
  assign load_entry = {AW'(region_base_next), region_bytes_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base      <= 32'd0;
      region_bytes     <= 32'd65536;
      level1_bytes     <= 16'd256;
      level2_bytes     <= 16'd256;
      descriptor_bytes <= 8'd8;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_REGION_BASE:      region_base      <= cfg_data;
        REG_REGION_BYTES:     region_bytes     <= cfg_data;
        REG_LEVEL1_BYTES:     level1_bytes     <= cfg_data[15:0];
        REG_LEVEL2_BYTES:     level2_bytes     <= cfg_data[15:0];
        REG_DESCRIPTOR_BYTES: descriptor_bytes <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Byte size of the requested table; a segment table is pages times the
  // descriptor size.
  always_comb begin
    case (in_data.table_kind)
      KIND_LEVEL1: size_req = SIZE_BITS'(level1_bytes);
      KIND_LEVEL2: size_req = SIZE_BITS'(level2_bytes);
      default:     size_req = SIZE_BITS'(in_data.segment_pages) * SIZE_BITS'(descriptor_bytes);
    endcase
  end

  // ---------------------------------------------------------------------
  // Segment store: base in the upper part of each word, length below.
  // ---------------------------------------------------------------------
  fftsa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_SEGMENTS)
  ) u_segments (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_base   = ram_rdata[EW-1:LEN_BITS];
  assign rd_len    = ram_rdata[LEN_BITS-1:0];
  assign rest      = rd_len - LEN_BITS'(size);
  assign fit       = chk_valid && (rd_len >= LEN_BITS'(size));
  assign shift_up  = rd_base > free_addr;
  assign new_entry = {free_addr, LEN_BITS'(size)};
  assign ptr_dec   = ptr - CW'(1);

  // The free walk runs downwards from the top of the list, every other walk
  // runs upwards.
  assign ram_raddr = (state == S_F_SCAN) ? ptr_dec[IW-1:0] : ptr[IW-1:0];

  always_comb begin
    fsm_we    = 1'b0;
    fsm_waddr = '0;
    fsm_wdata = '0;
    case (state)
      S_A_SCAN: begin
        // A partly used segment shrinks from its low end.
        if (fit && rest != '0) begin
          fsm_we    = 1'b1;
          fsm_waddr = chk_idx;
          fsm_wdata = {rd_base + AW'(size), rest};
        end
      end
      S_A_SHIFT: begin
        if (chk_valid) begin
          fsm_we    = 1'b1;
          fsm_waddr = chk_idx - IW'(1);
          fsm_wdata = ram_rdata;
        end
      end
      S_F_SCAN: begin
        // Each entry above the freed block moves up by one; the block goes
        // in just above the first entry whose base does not exceed it.
        if (chk_valid) begin
          fsm_we    = 1'b1;
          fsm_waddr = chk_idx + IW'(1);
          fsm_wdata = shift_up ? ram_rdata : new_entry;
        end else if (ptr == '0) begin
          fsm_we    = 1'b1;
          fsm_waddr = '0;
          fsm_wdata = new_entry;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (state == S_INIT || region_write) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = load_entry;
    end else begin
      ram_we    = fsm_we;
      ram_waddr = fsm_waddr;
      ram_wdata = fsm_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer. One entry is read per cycle; its data, held in the RAM's read
  // register, is judged with the index and valid flag kept in chk_idx and chk_valid.
  // ---------------------------------------------------------------------
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      count     <= CW'(1);
      ptr       <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // The finishing step sets the valid itself, so it is not cleared here.
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      if (region_write) begin
        count <= CW'(1);
      end
      case (state)
        S_INIT: begin
          state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            size      <= size_req;
            free_addr <= AW'(in_data.free_address);
            chk_valid <= 1'b0;
            if (in_data.opcode == OP_ALLOC) begin
              ptr   <= '0;
              state <= S_A_SCAN;
            end else if (count >= CW'(MAX_SEGMENTS)) begin
              res_addr   <= '0;
              res_status <= ST_FULL;
              state      <= S_FINISH;
            end else begin
              ptr   <= count;
              state <= S_F_SCAN;
            end
          end
        end
        S_A_SCAN: begin
          if (fit) begin
            res_addr   <= 32'(rd_base);
            res_status <= ST_OK;
            if (rest != '0) begin
              state <= S_FINISH;
            end else begin
              ptr       <= CW'(chk_idx) + CW'(1);
              chk_valid <= 1'b0;
              state     <= S_A_SHIFT;
            end
          end else if (ptr >= count && !chk_valid) begin
            res_addr   <= '0;
            res_status <= ST_NO_FIT;
            state      <= S_FINISH;
          end else begin
            chk_valid <= (ptr < count);
            chk_idx   <= ptr[IW-1:0];
            if (ptr < count) begin
              ptr <= ptr + CW'(1);
            end
          end
        end
        S_A_SHIFT: begin
          if (ptr >= count && !chk_valid) begin
            count <= count - CW'(1);
            state <= S_FINISH;
          end else begin
            chk_valid <= (ptr < count);
            chk_idx   <= ptr[IW-1:0];
            if (ptr < count) begin
              ptr <= ptr + CW'(1);
            end
          end
        end
        S_F_SCAN: begin
          if ((chk_valid && !shift_up) || (!chk_valid && ptr == '0)) begin
            count      <= count + CW'(1);
            res_addr   <= '0;
            res_status <= ST_OK;
            state      <= S_FINISH;
          end else begin
            chk_valid <= (ptr != '0);
            chk_idx   <= ptr_dec[IW-1:0];
            if (ptr != '0) begin
              ptr <= ptr_dec;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid              <= 1'b1;
            out_data.alloc_address <= res_addr;
            out_data.status        <= res_status;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  assign finishing      = (state == S_FINISH);
  assign has_room       = (count < CW'(MAX_SEGMENTS));
  assign res_full       = (res_status == ST_FULL);
  assign full_free_beat = in_valid && !in_stall && in_data.opcode == OP_FREE && !has_room;

  `FFTSA_ASSERT_NOW(a_out_rise, clk, rst, $rose(out_valid), $past(finishing), "stray result")
  `FFTSA_ASSERT_NOW(a_walk_room, clk, rst, state == S_F_SCAN, has_room, "free walk on full table")
  `FFTSA_ASSERT_NEXT(a_full_free, clk, rst, full_free_beat, finishing && res_full, "full free lost")

endmodule

@@ hdl/fftsa_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module fftsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the first-fit table space allocator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fftsa_pkg::*;

  // The package names only the first two table kinds; the segment table and
  // the unused code (handled as a segment table) are named here.
  localparam logic [1:0] KIND_SEGMENT = 2'd2;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  localparam int MAX_SEG        = 64;
  localparam int CHUNK_ITEMS    = 120;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int TAIL_CYCLES    = 150;
  // The limit leaves ample margin over the slowest plausible run of roughly 1800
  // requests.
  localparam int CYCLE_LIMIT    = 1000000;

  typedef struct {
    logic [31:0] addr;
    logic [1:0]  kind;
    logic [15:0] pages;
  } held_block_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  resp_t       out_data;

  first_fit_table_space_allocator #(
    .MAX_SEGMENTS(MAX_SEG),
    .ADDRESS_BITS(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial forever #5 clk = ~clk;

  // Our own copy of the register file and of the sorted free-segment table.
  logic [31:0] cfg_region_base;
  logic [31:0] cfg_region_bytes;
  logic [15:0] cfg_level1;
  logic [15:0] cfg_level2;
  logic [7:0]  cfg_desc;
  logic [31:0] free_seg_base [MAX_SEG];
  logic [31:0] free_seg_len  [MAX_SEG];
  int          free_seg_count;

  // Results still owed by the block, oldest first.
  resp_t       pending_results [$];
  // Blocks handed out and not yet returned, so that most frees are genuine.
  held_block_t held_blocks [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // The test asks for a hold-off by raising the first count; the receiver
  // catches up the second when it starts one.
  int holdoff_asked = 0;
  int holdoff_taken = 0;

  int errors = 0;
  int items_sent = 0;
  int reg_writes = 0;
  int n_placed = 0;
  int n_no_fit = 0;
  int n_full = 0;
  int n_stored = 0;
  int cycle_count;
  resp_t result_expected;

  // A region write reloads the table as one segment spanning the region.
  task automatic reload_region();
    free_seg_base[0] = cfg_region_base;
    free_seg_len[0]  = cfg_region_bytes;
    free_seg_count   = 1;
    held_blocks.delete();
  endtask

  function automatic logic [31:0] request_bytes(logic [1:0] kind, logic [15:0] pages);
    case (kind)
      KIND_LEVEL1: return {16'b0, cfg_level1};
      KIND_LEVEL2: return {16'b0, cfg_level2};
      default:     return 32'(pages) * 32'(cfg_desc);
    endcase
  endfunction

  // One request against the table: first fit on allocate, ordered insert on free.
  task automatic first_fit_step(input req_t r, output resp_t res);
    int i;
    int j;
    logic [31:0] size;
    size = request_bytes(r.table_kind, r.segment_pages);
    res.alloc_address = '0;
    res.status = ST_OK;
    if (r.opcode == OP_ALLOC) begin
      i = 0;
      while (i < free_seg_count && free_seg_len[i] < size) i++;
      if (i >= free_seg_count) begin
        res.status = ST_NO_FIT;
      end else begin
        res.alloc_address = free_seg_base[i];
        if (free_seg_len[i] != size) begin
          // The base wraps at the top of the address space.
          free_seg_base[i] = free_seg_base[i] + size;
          free_seg_len[i]  = free_seg_len[i] - size;
        end else begin
          for (j = i; j + 1 < free_seg_count; j++) begin
            free_seg_base[j] = free_seg_base[j + 1];
            free_seg_len[j]  = free_seg_len[j + 1];
          end
          free_seg_count--;
        end
      end
    end else if (free_seg_count >= MAX_SEG) begin
      res.status = ST_FULL;
    end else begin
      // Equal bases: the new block goes after those already present.
      i = 0;
      while (i < free_seg_count && free_seg_base[i] <= r.free_address) i++;
      for (j = free_seg_count; j > i; j--) begin
        free_seg_base[j] = free_seg_base[j - 1];
        free_seg_len[j]  = free_seg_len[j - 1];
      end
      free_seg_base[i] = r.free_address;
      free_seg_len[i]  = size;
      free_seg_count++;
    end
  endtask

  // Offers one beat, waits for it to be taken, and records what it must give.
  // The valid is left high on return, so a following beat is not broken up.
  task automatic send_request(input req_t r, output resp_t predicted);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    first_fit_step(r, predicted);
    pending_results.insert(pending_results.size(), predicted);
    items_sent++;
    case (predicted.status)
      ST_NO_FIT: n_no_fit++;
      ST_FULL:   n_full++;
      default: begin
        if (r.opcode == OP_ALLOC) n_placed++;
        else n_stored++;
      end
    endcase
  endtask

  task automatic send_fields(input logic op, input logic [1:0] kind, input logic [15:0] pages,
                             input logic [31:0] addr);
    req_t r;
    resp_t p;
    r.opcode = op;
    r.table_kind = kind;
    r.segment_pages = pages;
    r.free_address = addr;
    send_request(r, p);
  endtask

  // Drops the valid and waits until every owed result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    reg_writes++;
    case (idx)
      REG_REGION_BASE:      begin cfg_region_base = val; reload_region(); end
      REG_REGION_BYTES:     begin cfg_region_bytes = val; reload_region(); end
      REG_LEVEL1_BYTES:     cfg_level1 = val[15:0];
      REG_LEVEL2_BYTES:     cfg_level2 = val[15:0];
      REG_DESCRIPTOR_BYTES: cfg_desc = val[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_pages();
    int p;
    p = $urandom_range(99);
    if (p < 75) return 16'($urandom_range(40));
    if (p < 95) return 16'($urandom_range(2047));
    return 16'($urandom_range(65535));
  endfunction

  // A fresh random setting, with the extremes of each register turning up often.
  task automatic pick_setting();
    logic [31:0] v;
    case ($urandom_range(9))
      0: v = 32'd1;
      1: v = 32'd65535;
      default: v = $urandom_range(1, 512);
    endcase
    write_reg(REG_LEVEL1_BYTES, v);
    case ($urandom_range(9))
      0: v = 32'd1;
      1: v = 32'd65535;
      default: v = $urandom_range(1, 512);
    endcase
    write_reg(REG_LEVEL2_BYTES, v);
    case ($urandom_range(9))
      0: v = 32'd1;
      1: v = 32'd255;
      default: v = $urandom_range(1, 16);
    endcase
    write_reg(REG_DESCRIPTOR_BYTES, v);
    case ($urandom_range(9))
      0: v = 32'd0;
      1: v = 32'hFFFF_FFFF;
      default: v = $urandom;
    endcase
    write_reg(REG_REGION_BASE, v);
    case ($urandom_range(9))
      0: v = 32'd0;
      1: v = 32'hFFFF_FFFF;
      default: v = $urandom_range(1024, 131072);
    endcase
    write_reg(REG_REGION_BYTES, v);
  endtask

  // Half allocations, a third genuine frees of held blocks, the rest noise.
  task automatic random_request();
    int choice;
    int idx;
    req_t r;
    resp_t p;
    held_block_t b;
    choice = $urandom_range(99);
    r.opcode = OP_ALLOC;
    r.table_kind = 2'($urandom_range(3));
    r.segment_pages = pick_pages();
    r.free_address = $urandom;
    if (choice >= 85) begin
      r.opcode = 1'($urandom_range(1));
      r.segment_pages = 16'($urandom_range(65535));
    end else if (choice >= 50 && held_blocks.size() != 0) begin
      idx = $urandom_range(held_blocks.size() - 1);
      b = held_blocks[idx];
      held_blocks.delete(idx);
      r.opcode = OP_FREE;
      r.table_kind = b.kind;
      r.segment_pages = b.pages;
      r.free_address = b.addr;
    end
    send_request(r, p);
    if (r.opcode == OP_ALLOC && p.status == ST_OK) begin
      b.addr = p.alloc_address;
      b.kind = r.table_kind;
      b.pages = r.segment_pages;
      held_blocks.insert(held_blocks.size(), b);
    end
  endtask

  // Every kind, zero sizes, equal bases, exact fits and the top address,
  // all against the reset setting.
  task automatic test_basic_requests();
    send_fields(OP_ALLOC, KIND_LEVEL1, 16'd0, 32'd0);
    send_fields(OP_ALLOC, KIND_LEVEL2, 16'd0, 32'd0);
    send_fields(OP_ALLOC, KIND_SEGMENT, 16'd0, 32'd0);
    send_fields(OP_ALLOC, KIND_SPARE, 16'd4, 32'd0);
    send_fields(OP_ALLOC, KIND_SEGMENT, 16'hFFFF, 32'd0);
    send_fields(OP_FREE, KIND_LEVEL1, 16'd0, 32'd0);
    send_fields(OP_FREE, KIND_SEGMENT, 16'd0, 32'd0);
    send_fields(OP_FREE, KIND_LEVEL2, 16'd0, 32'hFFFF_FFFF);
    send_fields(OP_ALLOC, KIND_SEGMENT, 16'd32, 32'd0);
    send_fields(OP_ALLOC, KIND_SEGMENT, 16'd0, 32'd0);
    send_fields(OP_FREE, KIND_SPARE, 16'hFFFF, 32'hFFFF_FFFF);
    send_fields(OP_ALLOC, KIND_SEGMENT, 16'hFFFF, 32'd0);
    send_fields(OP_ALLOC, KIND_LEVEL1, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  // Extreme register values: a region that wraps past the top of the address
  // space, an emptied table, a zero-length region and the full address range.
  task automatic test_region_extremes();
    wait_idle();
    write_reg(REG_LEVEL1_BYTES, 32'd65535);
    write_reg(REG_LEVEL2_BYTES, 32'd1);
    write_reg(REG_DESCRIPTOR_BYTES, 32'd255);
    write_reg(REG_REGION_BASE, 32'hFFFF_FF00);
    write_reg(REG_REGION_BYTES, 32'h0001_0100);
    send_fields(OP_ALLOC, KIND_LEVEL1, 16'd0, 32'd0);
    send_fields(OP_ALLOC, KIND_LEVEL2, 16'd0, 32'd0);
    send_fields(OP_ALLOC, KIND_SEGMENT, 16'd1, 32'd0);
    send_fields(OP_ALLOC, KIND_LEVEL2, 16'd0, 32'd0);
    // The table is now empty, so even a zero-size request finds nothing.
    send_fields(OP_ALLOC, KIND_LEVEL2, 16'd0, 32'd0);
    send_fields(OP_ALLOC, KIND_SEGMENT, 16'd0, 32'd0);
    send_fields(OP_FREE, KIND_LEVEL2, 16'd0, 32'h0000_0010);
    wait_idle();
    write_reg(REG_REGION_BYTES, 32'd0);
    send_fields(OP_ALLOC, KIND_SEGMENT, 16'd0, 32'd0);
    send_fields(OP_ALLOC, KIND_LEVEL2, 16'd0, 32'd0);
    wait_idle();
    write_reg(REG_REGION_BASE, 32'd0);
    write_reg(REG_REGION_BYTES, 32'hFFFF_FFFF);
    send_fields(OP_ALLOC, KIND_SEGMENT, 16'hFFFF, 32'd0);
    send_fields(OP_ALLOC, KIND_LEVEL1, 16'd0, 32'd0);
    wait_idle();
    write_reg(REG_LEVEL1_BYTES, 32'd1);
    write_reg(REG_DESCRIPTOR_BYTES, 32'd1);
    send_fields(OP_ALLOC, KIND_LEVEL1, 16'd0, 32'd0);
    send_fields(OP_ALLOC, KIND_SPARE, 16'hFFFF, 32'd0);
  endtask

  // Frees until the table holds its last entry, a few refused on the full
  // table, then allocations and frees on the fragmented list.
  task automatic test_table_full();
    int n;
    req_t r;
    resp_t p;
    wait_idle();
    write_reg(REG_LEVEL1_BYTES, 32'd128);
    write_reg(REG_LEVEL2_BYTES, 32'd64);
    write_reg(REG_DESCRIPTOR_BYTES, 32'd4);
    write_reg(REG_REGION_BASE, $urandom);
    write_reg(REG_REGION_BYTES, 32'd32768);
    while (free_seg_count < MAX_SEG) begin
      r.opcode = OP_FREE;
      r.table_kind = 2'($urandom_range(3));
      r.segment_pages = 16'($urandom_range(16));
      r.free_address = $urandom;
      send_request(r, p);
    end
    for (n = 0; n < 4; n++) send_fields(OP_FREE, 2'($urandom_range(3)), 16'd1, $urandom);
    for (n = 0; n < 30; n++) begin
      send_fields(OP_ALLOC, 2'($urandom_range(3)), 16'($urandom_range(16)), $urandom);
    end
    for (n = 0; n < 10; n++) begin
      send_fields(OP_FREE, 2'($urandom_range(3)), 16'($urandom_range(16)), $urandom);
    end
  endtask

  // Random traffic in chunks, each chunk under a new register setting.
  task automatic test_random_traffic(input int items, input int s_pct, input int r_pct);
    int n;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (n = 0; n < items; n++) begin
      if (n % CHUNK_ITEMS == 0) begin
        wait_idle();
        pick_setting();
      end
      random_request();
    end
  endtask

  // The receiver refuses results for a long stretch while requests keep
  // coming, so the block fills and must hold its input.
  task automatic test_output_holdoff();
    int n;
    wait_idle();
    holdoff_asked++;
    for (n = 0; n < 12; n++) random_request();
  endtask

  // Receiver: random stall at the current rate, or a counted hold-off on request.
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (holdoff_asked != holdoff_taken) begin
        holdoff_taken = holdoff_asked;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Each result beat is matched against the oldest owed result, field by field.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing owed: expected none, got address %h status %0d",
                 $time, out_data.alloc_address, out_data.status);
      end else begin
        result_expected = pending_results[0];
        pending_results.delete(0);
        if (out_data.alloc_address !== result_expected.alloc_address) begin
          errors++;
          $display("%0t: alloc_address mismatch: expected %h, got %h", $time,
                   result_expected.alloc_address, out_data.alloc_address);
        end
        if (out_data.status !== result_expected.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, got %0d", $time,
                   result_expected.status, out_data.status);
        end
      end
    end
  end

  // Watchdog: the run is abandoned if it outlasts the cycle budget.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
             pending_results.size());
    $display("FAIL");
    $finish;
  end

  initial begin
    cfg_region_base  = 32'd0;
    cfg_region_bytes = 32'd65536;
    cfg_level1       = 16'd256;
    cfg_level2       = 16'd256;
    cfg_desc         = 8'd8;
    reload_region();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // The sender idles a third of the time and the receiver more than half.
    send_idle_pct = 32;
    recv_idle_pct = 58;
    test_basic_requests();
    test_region_extremes();
    test_table_full();
    test_random_traffic(540, 32, 58);
    // Then the rates swap, and last of all neither side idles.
    test_random_traffic(540, 58, 32);
    test_random_traffic(540, 0, 0);
    test_output_holdoff();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) errors++;

    $display("Covered %0d requests under %0d register writes in %0d cycles.", items_sent,
             reg_writes, cycle_count);
    $display("Allocations placed %0d, no fit %0d, frees stored %0d, refused as full %0d.",
             n_placed, n_no_fit, n_stored, n_full);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/fftsa_pkg.sv
hdl/fftsa_ram.sv
hdl/first_fit_table_space_allocator.sv
test/tb.sv
